/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge, ignored while reset is high.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/cssh_pkg.sv */
// ----------------------------------------------------------------------------
// cssh_pkg
// Types, codes and reset values of the client session handshake block.
// ----------------------------------------------------------------------------
package cssh_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_EVENT = 2'd1,
      REQ_START = 2'd2
   } cssh_req_kind_type;

   typedef enum logic [2:0] {
      EV_CONNECT    = 3'd0,
      EV_JOIN_READY = 3'd1,
      EV_FRAGMENT   = 3'd2,
      EV_DISCONNECT = 3'd3,
      EV_OTHER      = 3'd4
   } cssh_event_type;

   typedef enum logic [3:0] {
      ACT_NONE         = 4'd0,
      ACT_SEND_CONNECT = 4'd1,
      ACT_SEND_INFO    = 4'd2,
      ACT_SEND_DISC    = 4'd3,
      ACT_ADD_PLAYER   = 4'd4,
      ACT_REMOVE       = 4'd5,
      ACT_DELIVER      = 4'd6,
      ACT_CLIENT_DEAD  = 4'd7,
      ACT_BAD_FRAG     = 4'd8
   } cssh_action_type;

   typedef enum logic [3:0] {
      PH_NONE         = 4'd0,
      PH_INIT         = 4'd1,
      PH_TRY_CONNECT  = 4'd2,
      PH_CONNECT_WAIT = 4'd3,
      PH_DEAD         = 4'd4,
      PH_CONNECTED    = 4'd5,
      PH_TRY_JOIN     = 4'd6,
      PH_JOIN_WAIT    = 4'd7,
      PH_JOIN_ACK     = 4'd8,
      PH_JOINED       = 4'd9,
      PH_DISCONNECTED = 4'd10
   } cssh_phase_type;

   typedef enum logic [1:0] {
      BUF_NONE     = 2'd0,
      BUF_PARTIAL  = 2'd1,
      BUF_COMPLETE = 2'd2
   } cssh_buf_type;

   typedef enum logic [2:0] {
      REG_CONNECT_START = 3'd0,
      REG_CONNECT_WAIT  = 3'd1,
      REG_JOIN_START    = 3'd2,
      REG_JOIN_WAIT     = 3'd3,
      REG_ALIVE_PERIOD  = 3'd4
   } cssh_reg_type;

   localparam logic [15:0] CONNECT_START_RESET = 16'd1000;
   localparam logic [15:0] CONNECT_WAIT_RESET  = 16'd5000;
   localparam logic [15:0] JOIN_START_RESET    = 16'd1000;
   localparam logic [15:0] JOIN_WAIT_RESET     = 16'd30000;
   localparam logic [15:0] ALIVE_PERIOD_RESET  = 16'd5000;

   typedef struct packed {
      logic [15:0] connect_start_delay;
      logic [15:0] connect_wait_limit;
      logic [15:0] join_start_delay;
      logic [15:0] join_wait_limit;
      logic [15:0] alive_period;
   } cssh_cfg_type;

   typedef struct packed {
      cssh_req_kind_type req_type;
      logic [31:0]       now;
      cssh_event_type    event_kind;
      logic [15:0]       frag_id;
      logic              frag_complete;
      logic [15:0]       fresh_id;
   } cssh_item_type;

   typedef struct packed {
      cssh_phase_type phase;
      logic [31:0]    deadline;
      logic [15:0]    assigned_player;
      logic           player_assigned;
      logic           heard_from_client;
      logic [15:0]    newest_frag;
      cssh_buf_type   buffer_status;
   } cssh_state_type;

   typedef struct packed {
      cssh_action_type action;
      logic [15:0]     player_id;
      cssh_phase_type  phase;
      logic            last;
   } cssh_result_type;

   typedef struct packed {
      cssh_result_type first;
      cssh_result_type second;
      logic            two;
   } cssh_step_out_type;

   localparam cssh_state_type STATE_RESET = '{
      phase:             PH_NONE,
      deadline:          32'd0,
      assigned_player:   16'd0,
      player_assigned:   1'b0,
      heard_from_client: 1'b0,
      newest_frag:       16'd0,
      buffer_status:     BUF_NONE
   };

endpackage

/* hw/rtl/cssh_req_if.sv */
// ----------------------------------------------------------------------------
// cssh_req_if
// Input channel: ticks, client events and session starts.
// ----------------------------------------------------------------------------
interface cssh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] now;
   logic [2:0]  event_kind;
   logic [15:0] frag_id;
   logic        frag_complete;
   logic [15:0] fresh_id;

   modport source (
      output valid, req_type, now, event_kind, frag_id, frag_complete, fresh_id,
      input  ready
   );
   modport sink (
      input  valid, req_type, now, event_kind, frag_id, frag_complete, fresh_id,
      output ready
   );
endinterface

/* hw/rtl/cssh_rsp_if.sv */
// ----------------------------------------------------------------------------
// cssh_rsp_if
// Result channel: one action beat at a time.
// ----------------------------------------------------------------------------
interface cssh_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [15:0] player_id;
   logic [3:0]  phase;
   logic        last;

   modport source (
      output valid, action, player_id, phase, last,
      input  ready
   );
   modport sink (
      input  valid, action, player_id, phase, last,
      output ready
   );
endinterface

/* hw/rtl/cssh_step.sv */
// ----------------------------------------------------------------------------
// cssh_step
// Next session state and the one or two result beats for one item.
// ----------------------------------------------------------------------------
module cssh_step (
   input  cssh_pkg::cssh_cfg_type      cfg,
   input  cssh_pkg::cssh_state_type    cur,
   input  cssh_pkg::cssh_item_type     item,
   output cssh_pkg::cssh_state_type    nxt,
   output cssh_pkg::cssh_step_out_type res
);

   logic [15:0]               delay_sel;
   logic [31:0]               armed;
   logic                      due;
   cssh_pkg::cssh_action_type a0;
   cssh_pkg::cssh_action_type a1;
   logic [15:0]               p0;
   logic [15:0]               p1;
   logic                      two;

   // pick the delay for the phase a tick would arm from
   always_comb begin
      case (cur.phase)
         cssh_pkg::PH_INIT:        delay_sel = cfg.connect_start_delay;
         cssh_pkg::PH_TRY_CONNECT: delay_sel = cfg.connect_wait_limit;
         cssh_pkg::PH_CONNECTED:   delay_sel = cfg.join_start_delay;
         cssh_pkg::PH_TRY_JOIN:    delay_sel = cfg.join_wait_limit;
         default:                  delay_sel = cfg.alive_period;
      endcase
   end

   assign armed = item.now + {16'd0, delay_sel};
   assign due   = (item.now >= cur.deadline);

   always_comb begin
      nxt = cur;
      a0  = cssh_pkg::ACT_NONE;
      a1  = cssh_pkg::ACT_NONE;
      p0  = 16'd0;
      p1  = 16'd0;
      two = 1'b0;
      case (item.req_type)
         cssh_pkg::REQ_TICK: begin
            if (due) begin
               case (cur.phase)
                  cssh_pkg::PH_INIT: begin
                     nxt.phase    = cssh_pkg::PH_TRY_CONNECT;
                     nxt.deadline = armed;
                  end
                  cssh_pkg::PH_TRY_CONNECT: begin
                     nxt.phase    = cssh_pkg::PH_CONNECT_WAIT;
                     nxt.deadline = armed;
                     a0           = cssh_pkg::ACT_SEND_CONNECT;
                  end
                  cssh_pkg::PH_CONNECT_WAIT, cssh_pkg::PH_JOIN_WAIT: begin
                     nxt.phase = cssh_pkg::PH_DEAD;
                     a0        = cssh_pkg::ACT_CLIENT_DEAD;
                  end
                  cssh_pkg::PH_CONNECTED: begin
                     nxt.phase    = cssh_pkg::PH_TRY_JOIN;
                     nxt.deadline = armed;
                  end
                  cssh_pkg::PH_TRY_JOIN: begin
                     nxt.assigned_player = item.fresh_id;
                     nxt.player_assigned = 1'b1;
                     nxt.phase           = cssh_pkg::PH_JOIN_WAIT;
                     nxt.deadline        = armed;
                     a0                  = cssh_pkg::ACT_SEND_INFO;
                     p0                  = item.fresh_id;
                  end
                  cssh_pkg::PH_JOIN_ACK: begin
                     nxt.phase = cssh_pkg::PH_JOINED;
                     a0        = cssh_pkg::ACT_ADD_PLAYER;
                     p0        = cur.assigned_player;
                  end
                  cssh_pkg::PH_JOINED: begin
                     if (!cur.heard_from_client) begin
                        // missed liveness: drop the player, then disconnect
                        if (cur.player_assigned) begin
                           a0  = cssh_pkg::ACT_REMOVE;
                           p0  = cur.assigned_player;
                           a1  = cssh_pkg::ACT_SEND_DISC;
                           two = 1'b1;
                        end else begin
                           a0 = cssh_pkg::ACT_SEND_DISC;
                        end
                        nxt.player_assigned = 1'b0;
                        nxt.phase           = cssh_pkg::PH_NONE;
                     end else begin
                        if (cur.buffer_status == cssh_pkg::BUF_COMPLETE) begin
                           a0                = cssh_pkg::ACT_DELIVER;
                           nxt.buffer_status = cssh_pkg::BUF_NONE;
                        end
                        nxt.heard_from_client = 1'b0;
                        nxt.deadline          = armed;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cssh_pkg::REQ_EVENT: begin
            nxt.heard_from_client = 1'b1;
            case (item.event_kind)
               cssh_pkg::EV_CONNECT: begin
                  if (cur.phase == cssh_pkg::PH_CONNECT_WAIT) begin
                     nxt.deadline = 32'd0;
                     nxt.phase    = cssh_pkg::PH_CONNECTED;
                  end
               end
               cssh_pkg::EV_JOIN_READY: begin
                  if (cur.phase == cssh_pkg::PH_JOIN_WAIT) begin
                     nxt.deadline = 32'd0;
                     nxt.phase    = cssh_pkg::PH_JOIN_ACK;
                  end
               end
               cssh_pkg::EV_FRAGMENT: begin
                  if (item.frag_id == 16'd0) begin
                     a0 = cssh_pkg::ACT_BAD_FRAG;
                  end else if (item.frag_id > cur.newest_frag) begin
                     // newer fragment starts a fresh buffer
                     nxt.newest_frag = item.frag_id;
                     if (item.frag_complete) begin
                        nxt.buffer_status = cssh_pkg::BUF_COMPLETE;
                        nxt.deadline      = 32'd0;
                     end else begin
                        nxt.buffer_status = cssh_pkg::BUF_PARTIAL;
                     end
                  end else if (item.frag_id == cur.newest_frag) begin
                     if (item.frag_complete &&
                         cur.buffer_status == cssh_pkg::BUF_PARTIAL) begin
                        nxt.buffer_status = cssh_pkg::BUF_COMPLETE;
                        nxt.deadline      = 32'd0;
                     end
                  end
               end
               cssh_pkg::EV_DISCONNECT: begin
                  if (cur.player_assigned) begin
                     a0 = cssh_pkg::ACT_REMOVE;
                     p0 = cur.assigned_player;
                  end
                  nxt.player_assigned = 1'b0;
                  nxt.phase           = cssh_pkg::PH_NONE;
               end
               default: begin
               end
            endcase
         end
         cssh_pkg::REQ_START: begin
            nxt.phase           = cssh_pkg::PH_INIT;
            nxt.deadline        = 32'd0;
            nxt.assigned_player = 16'd0;
            nxt.player_assigned = 1'b0;
            nxt.newest_frag     = 16'd0;
            nxt.buffer_status   = cssh_pkg::BUF_NONE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res.two              = two;
      res.first.action     = a0;
      res.first.player_id  = p0;
      res.first.phase      = nxt.phase;
      res.first.last       = !two;
      res.second.action    = a1;
      res.second.player_id = p1;
      res.second.phase     = nxt.phase;
      res.second.last      = 1'b1;
   end

endmodule

/* hw/rtl/client_session_handshake_fsm_core.sv */
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle when each gives one beat and results are taken;
// a two-beat item holds back further items until its last beat is leaving; the
// single result port draining the 2-entry buffer sets it.
// Reset: synchronous, active high; clears session state and loads the register
// defaults directly, with no clearing pass.
// ----------------------------------------------------------------------------
// client_session_handshake_fsm_core
// Server-side session handshake for one client: phase sequencing, deadlines,
// liveness checks and fragment tracking, with an APB-style register port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module client_session_handshake_fsm_core (
   input  logic                                clock,
   input  logic                                reset,
   cssh_req_if.sink                            req_in,
   cssh_rsp_if.source                          rsp_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cssh_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cssh_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cssh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   cssh_pkg::cssh_cfg_type      cfg_ff, cfg_in;
   cssh_pkg::cssh_state_type    state_ff, state_in;
   cssh_pkg::cssh_item_type     item_ff, item_in;
   logic                        item_vld_ff, item_vld_in;
   cssh_pkg::cssh_result_type   slot0_ff, slot0_in;
   cssh_pkg::cssh_result_type   slot1_ff, slot1_in;
   logic [1:0]                  out_cnt_ff, out_cnt_in;

   cssh_pkg::cssh_state_type    step_state;
   cssh_pkg::cssh_step_out_type step_res;
   cssh_pkg::cssh_reg_type      csr_idx;
   logic                        csr_wr;
   logic                        req_take;
   logic                        rsp_pop;
   logic                        advance;

   // ---------------------------------------------------------------------
   // Register port: write on the access phase, read back on any cycle
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = cssh_pkg::cssh_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            cssh_pkg::REG_CONNECT_START: cfg_in.connect_start_delay = csr_pwdata[15:0];
            cssh_pkg::REG_CONNECT_WAIT:  cfg_in.connect_wait_limit  = csr_pwdata[15:0];
            cssh_pkg::REG_JOIN_START:    cfg_in.join_start_delay    = csr_pwdata[15:0];
            cssh_pkg::REG_JOIN_WAIT:     cfg_in.join_wait_limit     = csr_pwdata[15:0];
            cssh_pkg::REG_ALIVE_PERIOD:  cfg_in.alive_period        = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         cssh_pkg::REG_CONNECT_START: csr_prdata = {16'd0, cfg_ff.connect_start_delay};
         cssh_pkg::REG_CONNECT_WAIT:  csr_prdata = {16'd0, cfg_ff.connect_wait_limit};
         cssh_pkg::REG_JOIN_START:    csr_prdata = {16'd0, cfg_ff.join_start_delay};
         cssh_pkg::REG_JOIN_WAIT:     csr_prdata = {16'd0, cfg_ff.join_wait_limit};
         cssh_pkg::REG_ALIVE_PERIOD:  csr_prdata = {16'd0, cfg_ff.alive_period};
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake control
   // The item register advances into the result buffer once the buffer can
   // take both beats of an item: empty, or down to its last beat which
   // leaves this cycle. Ready follows the item register, not the state.
   // ---------------------------------------------------------------------
   assign rsp_pop  = (out_cnt_ff != 2'd0) && rsp_out.ready;
   assign advance  = item_vld_ff &&
                     ((out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_pop));
   assign req_in.ready = !item_vld_ff || advance;
   assign req_take     = req_in.valid && req_in.ready;

   // capture the incoming beat
   always_comb begin
      item_vld_in           = req_take || (item_vld_ff && !advance);
      item_in               = item_ff;
      if (req_take) begin
         item_in.req_type      = cssh_pkg::cssh_req_kind_type'(req_in.req_type);
         item_in.now           = req_in.now;
         item_in.event_kind    = cssh_pkg::cssh_event_type'(req_in.event_kind);
         item_in.frag_id       = req_in.frag_id;
         item_in.frag_complete = req_in.frag_complete;
         item_in.fresh_id      = req_in.fresh_id;
      end
   end

   // ---------------------------------------------------------------------
   // Session step
   // ---------------------------------------------------------------------
   cssh_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (step_state),
      .res  (step_res)
   );

   // commit the new state only when the item moves on
   assign state_in = advance ? step_state : state_ff;

   // ---------------------------------------------------------------------
   // Result buffer: two entries, head in slot0
   // ---------------------------------------------------------------------
   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      out_cnt_in = out_cnt_ff;
      if (advance) begin
         // buffer is empty after this edge's pop, so load both slots
         slot0_in   = step_res.first;
         slot1_in   = step_res.second;
         out_cnt_in = step_res.two ? 2'd2 : 2'd1;
      end else if (rsp_pop) begin
         // advance the second beat to the head
         slot0_in   = slot1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   assign rsp_out.valid     = (out_cnt_ff != 2'd0);
   assign rsp_out.action    = slot0_ff.action;
   assign rsp_out.player_id = slot0_ff.player_id;
   assign rsp_out.phase     = slot0_ff.phase;
   assign rsp_out.last      = slot0_ff.last;

   // ---------------------------------------------------------------------
   // Clocked blocks
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         out_cnt_ff  <= 2'd0;
         state_ff    <= cssh_pkg::STATE_RESET;
         cfg_ff.connect_start_delay <= cssh_pkg::CONNECT_START_RESET;
         cfg_ff.connect_wait_limit  <= cssh_pkg::CONNECT_WAIT_RESET;
         cfg_ff.join_start_delay    <= cssh_pkg::JOIN_START_RESET;
         cfg_ff.join_wait_limit     <= cssh_pkg::JOIN_WAIT_RESET;
         cfg_ff.alive_period        <= cssh_pkg::ALIVE_PERIOD_RESET;
      end else begin
         item_vld_ff <= item_vld_in;
         out_cnt_ff  <= out_cnt_in;
         state_ff    <= state_in;
         cfg_ff      <= cfg_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // the first beat of a pair always has its partner queued behind it
   `ASSERT_SYNC(a_pair_held, clock, reset,
      ((out_cnt_ff != 2'd0) && !slot0_ff.last) |-> (out_cnt_ff == 2'd2),
      "first beat of a pair without its partner")
   // every item that leaves the input register shows a result beat next cycle
   `ASSERT_SYNC(a_adv_result, clock, reset,
      advance |=> rsp_out.valid,
      "advanced item produced no result beat")
   // a held item stays in the input register
   `ASSERT_SYNC(a_item_kept, clock, reset,
      (item_vld_ff && !advance) |=> item_vld_ff,
      "stalled item dropped")
   // the disconnected phase is transient and never stored
   `ASSERT_SYNC(a_no_disc_phase, clock, reset,
      state_ff.phase != cssh_pkg::PH_DISCONNECTED,
      "transient phase stored")
   // a session start always lands in init with no player
   `ASSERT_SYNC(a_start_init, clock, reset,
      (advance && (item_ff.req_type == cssh_pkg::REQ_START)) |=>
         ((state_ff.phase == cssh_pkg::PH_INIT) && !state_ff.player_assigned),
      "session start did not reach init")

endmodule

/* tb/sv/tb_client_session_handshake_fsm_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_client_session_handshake_fsm_core
// Self-checking bench for the client session handshake core. A driver offers
// ticks, client events and session starts from a queue, a built-in session
// predictor computes the action beats that each accepted request must give,
// and a monitor compares every returned beat against them in order. Register
// settings change between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_client_session_handshake_fsm_core;

   // One request as it travels on the input channel; plain vectors so that
   // undefined request and event codes can be sent as well.
   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now;
      logic [2:0]  event_kind;
      logic [15:0] frag_id;
      logic        frag_complete;
      logic [15:0] fresh_id;
   } session_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cssh_req_if req_chan ();
   cssh_rsp_if rsp_chan ();

   // Bench-side drivers, all known from time zero.
   logic                            req_valid_q   = 1'b0;
   session_req_type                 req_beat      = '0;
   logic                            rsp_ready_q   = 1'b0;
   logic                            csr_psel_q    = 1'b0;
   logic                            csr_penable_q = 1'b0;
   logic                            csr_pwrite_q  = 1'b0;
   logic [cssh_pkg::CSR_ADDR_W-1:0] csr_paddr_q   = '0;
   logic [cssh_pkg::CSR_DATA_W-1:0] csr_pwdata_q  = '0;
   logic [cssh_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   assign req_chan.valid         = req_valid_q;
   assign req_chan.req_type      = req_beat.req_type;
   assign req_chan.now           = req_beat.now;
   assign req_chan.event_kind    = req_beat.event_kind;
   assign req_chan.frag_id       = req_beat.frag_id;
   assign req_chan.frag_complete = req_beat.frag_complete;
   assign req_chan.fresh_id      = req_beat.fresh_id;
   assign rsp_chan.ready         = rsp_ready_q;

   client_session_handshake_fsm_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_in      (req_chan),
      .rsp_out     (rsp_chan),
      .csr_psel    (csr_psel_q),
      .csr_penable (csr_penable_q),
      .csr_pwrite  (csr_pwrite_q),
      .csr_paddr   (csr_paddr_q),
      .csr_pwdata  (csr_pwdata_q),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Session predictor: a shadow copy of the session state and the delay
   // registers, advanced once per accepted request.
   // -------------------------------------------------------------------------
   cssh_pkg::cssh_state_type  sess   = cssh_pkg::STATE_RESET;
   cssh_pkg::cssh_cfg_type    delays = '{cssh_pkg::CONNECT_START_RESET,
                                         cssh_pkg::CONNECT_WAIT_RESET,
                                         cssh_pkg::JOIN_START_RESET,
                                         cssh_pkg::JOIN_WAIT_RESET,
                                         cssh_pkg::ALIVE_PERIOD_RESET};
   cssh_pkg::cssh_action_type step_act [2];
   logic [15:0]               step_pid [2];
   int                        step_n;
   cssh_pkg::cssh_result_type expected_beats [$];

   // Record one action of the current step; at most two fit.
   function automatic void note_action(input cssh_pkg::cssh_action_type act,
                                       input bit with_player);
      if (step_n < 2) begin
         step_act[step_n] = act;
         step_pid[step_n] = with_player ? sess.assigned_player : 16'd0;
         step_n++;
      end
   endfunction

   // Tear the session down: drop the player, tell the client unless it left.
   function automatic void end_session(input bit client_left);
      if (sess.player_assigned) note_action(cssh_pkg::ACT_REMOVE, 1'b1);
      sess.player_assigned = 1'b0;
      if (!client_left) note_action(cssh_pkg::ACT_SEND_DISC, 1'b0);
      sess.phase = cssh_pkg::PH_NONE;
   endfunction

   function automatic void predict_session_step(input session_req_type r);
      step_n = 0;
      case (r.req_type)
         cssh_pkg::REQ_TICK: begin
            // A tick only acts once the deadline is reached (unsigned compare).
            if (r.now >= sess.deadline) begin
               case (sess.phase)
                  cssh_pkg::PH_INIT: begin
                     sess.phase    = cssh_pkg::PH_TRY_CONNECT;
                     sess.deadline = r.now + {16'd0, delays.connect_start_delay};
                  end
                  cssh_pkg::PH_TRY_CONNECT: begin
                     sess.phase    = cssh_pkg::PH_CONNECT_WAIT;
                     sess.deadline = r.now + {16'd0, delays.connect_wait_limit};
                     note_action(cssh_pkg::ACT_SEND_CONNECT, 1'b0);
                  end
                  cssh_pkg::PH_CONNECT_WAIT, cssh_pkg::PH_JOIN_WAIT: begin
                     sess.phase = cssh_pkg::PH_DEAD;
                     note_action(cssh_pkg::ACT_CLIENT_DEAD, 1'b0);
                  end
                  cssh_pkg::PH_CONNECTED: begin
                     sess.phase    = cssh_pkg::PH_TRY_JOIN;
                     sess.deadline = r.now + {16'd0, delays.join_start_delay};
                  end
                  cssh_pkg::PH_TRY_JOIN: begin
                     // The join offer takes the fresh id of this very tick.
                     sess.assigned_player = r.fresh_id;
                     sess.player_assigned = 1'b1;
                     sess.phase           = cssh_pkg::PH_JOIN_WAIT;
                     sess.deadline        = r.now + {16'd0, delays.join_wait_limit};
                     note_action(cssh_pkg::ACT_SEND_INFO, 1'b1);
                  end
                  cssh_pkg::PH_JOIN_ACK: begin
                     sess.phase = cssh_pkg::PH_JOINED;
                     note_action(cssh_pkg::ACT_ADD_PLAYER, 1'b1);
                  end
                  cssh_pkg::PH_JOINED: begin
                     if (!sess.heard_from_client) begin
                        end_session(1'b0);
                     end else begin
                        if (sess.buffer_status == cssh_pkg::BUF_COMPLETE) begin
                           note_action(cssh_pkg::ACT_DELIVER, 1'b0);
                           sess.buffer_status = cssh_pkg::BUF_NONE;
                        end
                        sess.heard_from_client = 1'b0;
                        sess.deadline = r.now + {16'd0, delays.alive_period};
                     end
                  end
                  default: ;
               endcase
            end
         end
         cssh_pkg::REQ_EVENT: begin
            sess.heard_from_client = 1'b1;
            if (sess.phase == cssh_pkg::PH_CONNECT_WAIT &&
                r.event_kind == cssh_pkg::EV_CONNECT) begin
               sess.deadline = '0;
               sess.phase    = cssh_pkg::PH_CONNECTED;
            end
            if (sess.phase == cssh_pkg::PH_JOIN_WAIT &&
                r.event_kind == cssh_pkg::EV_JOIN_READY) begin
               sess.deadline = '0;
               sess.phase    = cssh_pkg::PH_JOIN_ACK;
            end
            if (r.event_kind == cssh_pkg::EV_FRAGMENT) begin
               if (r.frag_id == '0) begin
                  note_action(cssh_pkg::ACT_BAD_FRAG, 1'b0);
               end else if (r.frag_id >= sess.newest_frag) begin
                  // Older ids are dropped; a newer one opens a fresh buffer.
                  if (r.frag_id > sess.newest_frag) begin
                     sess.newest_frag   = r.frag_id;
                     sess.buffer_status = cssh_pkg::BUF_PARTIAL;
                  end
                  if (r.frag_complete && sess.buffer_status == cssh_pkg::BUF_PARTIAL) begin
                     sess.buffer_status = cssh_pkg::BUF_COMPLETE;
                     sess.deadline      = '0;
                  end
               end
            end
            if (r.event_kind == cssh_pkg::EV_DISCONNECT) begin
               sess.phase = cssh_pkg::PH_DISCONNECTED;
               end_session(1'b1);
            end
         end
         cssh_pkg::REQ_START: begin
            // Heard-from-client survives a restart on purpose.
            sess.phase           = cssh_pkg::PH_INIT;
            sess.deadline        = '0;
            sess.assigned_player = '0;
            sess.player_assigned = 1'b0;
            sess.newest_frag     = '0;
            sess.buffer_status   = cssh_pkg::BUF_NONE;
         end
         default: ;
      endcase
      if (step_n == 0) note_action(cssh_pkg::ACT_NONE, 1'b0);
      for (int k = 0; k < step_n; k++) begin
         expected_beats.push_back('{action: step_act[k], player_id: step_pid[k],
                                    phase: sess.phase, last: (k == step_n - 1)});
      end
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch bookkeeping: report the first ten, count the rest.
   // -------------------------------------------------------------------------
   int mismatch_cnt = 0;

   function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offer queued requests, hold each until the core takes it, and
   // predict the beats of every accepted request on the spot.
   // -------------------------------------------------------------------------
   session_req_type pending_reqs [$];
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     accepted_cnt  = 0;
   logic            hold_off      = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
      end else begin
         if (req_valid_q && req_chan.ready) begin
            predict_session_step(req_beat);
            accepted_cnt++;
         end
         // Advance only when the slot is empty or being taken this edge.
         if (!req_valid_q || req_chan.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_beat    <= pending_reqs.pop_front();
               req_valid_q <= 1'b1;
            end else begin
               req_valid_q <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check each returned beat against the oldest prediction, then
   // pick the next ready value (dropped for the whole hold-off stretch).
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cssh_pkg::cssh_result_type want;
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_ready_q) begin
            if (expected_beats.size() == 0) begin
               flag_mismatch("beat with nothing expected, action", '0, rsp_chan.action);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_chan.action !== want.action)
                  flag_mismatch("action", want.action, rsp_chan.action);
               if (rsp_chan.player_id !== want.player_id)
                  flag_mismatch("player_id", want.player_id, rsp_chan.player_id);
               if (rsp_chan.phase !== want.phase)
                  flag_mismatch("phase", want.phase, rsp_chan.phase);
               if (rsp_chan.last !== want.last)
                  flag_mismatch("last", want.last, rsp_chan.last);
            end
         end
         rsp_ready_q <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Back-pressure: once traffic is flowing, stall the result side long
   // enough for the core to fill up and push back on the request side.
   initial begin
      wait (accepted_cnt >= 200);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   logic [31:0] stim_ms    = '0;
   logic [15:0] frag_seq   = '0;
   bit          noise_on   = 1'b0;
   int unsigned items_made = 0;

   function automatic bit chance(input int unsigned n);
      return $urandom_range(n - 1) == 0;
   endfunction

   // Move the clock past a delay, now and then stop short of it.
   function automatic void advance(input logic [15:0] delay);
      if (chance(8)) stim_ms += $urandom_range(delay);
      else           stim_ms += delay + $urandom_range(20);
   endfunction

   // Queue one request; with noise on, sometimes slip in a random one after it.
   task automatic queue_req(input logic [1:0] kind_of_req, input logic [31:0] at_ms,
                            input logic [2:0] ev, input logic [15:0] fid,
                            input logic cpl, input logic [15:0] fresh);
      pending_reqs.push_back('{req_type: kind_of_req, now: at_ms, event_kind: ev,
                               frag_id: fid, frag_complete: cpl, fresh_id: fresh});
      items_made++;
      if (noise_on && chance(16)) begin
         pending_reqs.push_back('{req_type: 2'($urandom_range(3)),
                                  now: chance(2) ? $urandom : stim_ms + $urandom_range(100),
                                  event_kind: 3'($urandom_range(7)),
                                  frag_id: 16'($urandom), frag_complete: 1'($urandom),
                                  fresh_id: 16'($urandom)});
         items_made++;
      end
   endtask

   task automatic queue_tick();
      queue_req(cssh_pkg::REQ_TICK, stim_ms, 3'($urandom), 16'($urandom), 1'($urandom),
                16'($urandom));
   endtask

   task automatic queue_event(input logic [2:0] ev);
      queue_req(cssh_pkg::REQ_EVENT, stim_ms, ev, 16'($urandom), 1'($urandom),
                16'($urandom));
   endtask

   // Fragment ids: mostly climbing, with repeats, stale ids, zero and top values.
   task automatic queue_fragment();
      logic [15:0] fid;
      case ($urandom_range(9))
         0:       fid = '0;
         1, 2:    fid = frag_seq;
         3:       fid = (frag_seq > 1) ? 16'($urandom_range(frag_seq - 1, 1)) : 16'd1;
         4:       fid = 16'($urandom_range(16'hFFFF, 16'hFF00));
         default: fid = frag_seq + 16'($urandom_range(3, 1));
      endcase
      if (fid > frag_seq) frag_seq = fid;
      queue_req(cssh_pkg::REQ_EVENT, stim_ms, cssh_pkg::EV_FRAGMENT, fid, 1'($urandom),
                16'($urandom));
   endtask

   // One session walked through its phases with timing drawn from the
   // current delays; some sessions time out, go silent or are cut short.
   task automatic queue_session();
      int unsigned rounds;
      if (chance(16)) stim_ms = 32'hFFFF_FFFF - $urandom_range(70000);
      frag_seq = '0;
      queue_req(cssh_pkg::REQ_START, stim_ms, 3'($urandom), 16'($urandom), 1'($urandom),
                16'($urandom));
      queue_tick();
      advance(delays.connect_start_delay);
      queue_tick();
      if (chance(8)) begin
         // Let the connect wait run out.
         advance(delays.connect_wait_limit);
         queue_tick();
         queue_tick();
         return;
      end
      if (chance(4)) queue_fragment();
      queue_event(cssh_pkg::EV_CONNECT);
      queue_tick();
      advance(delays.join_start_delay);
      queue_tick();
      if (chance(3)) queue_fragment();
      if (chance(8)) begin
         // Let the join wait run out.
         advance(delays.join_wait_limit);
         queue_tick();
         queue_tick();
         return;
      end
      queue_event(cssh_pkg::EV_JOIN_READY);
      queue_tick();
      queue_tick();
      rounds = $urandom_range(6, 1);
      repeat (rounds) begin
         // Stay quiet now and then so the liveness check drops the client.
         if (!chance(6)) begin
            repeat ($urandom_range(3)) begin
               case ($urandom_range(4))
                  0:       queue_event(3'($urandom_range(7, 4)));
                  1:       queue_event(chance(2) ? cssh_pkg::EV_CONNECT
                                                 : cssh_pkg::EV_JOIN_READY);
                  default: queue_fragment();
               endcase
            end
         end
         advance(delays.alive_period);
         queue_tick();
      end
      if (chance(2)) begin
         queue_event(cssh_pkg::EV_DISCONNECT);
      end else begin
         advance(delays.alive_period);
         queue_tick();
      end
   endtask

   // Register write followed by a read-back; shadow the new value.
   task automatic write_reg(input cssh_pkg::cssh_reg_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_psel_q    <= 1'b1;
      csr_penable_q <= 1'b0;
      csr_pwrite_q  <= 1'b1;
      csr_paddr_q   <= {idx, 2'b00};
      csr_pwdata_q  <= {16'd0, value};
      @(posedge clock);
      csr_penable_q <= 1'b1;
      @(posedge clock);
      // Write lands on this edge; turn the transfer into a read setup.
      csr_penable_q <= 1'b0;
      csr_pwrite_q  <= 1'b0;
      @(posedge clock);
      csr_penable_q <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {16'd0, value})
         flag_mismatch("register readback", {16'd0, value}, csr_prdata);
      csr_psel_q    <= 1'b0;
      csr_penable_q <= 1'b0;
      case (idx)
         cssh_pkg::REG_CONNECT_START: delays.connect_start_delay = value;
         cssh_pkg::REG_CONNECT_WAIT:  delays.connect_wait_limit  = value;
         cssh_pkg::REG_JOIN_START:    delays.join_start_delay    = value;
         cssh_pkg::REG_JOIN_WAIT:     delays.join_wait_limit     = value;
         cssh_pkg::REG_ALIVE_PERIOD:  delays.alive_period        = value;
         default: ;
      endcase
   endtask

   // Hold until every request is taken and every beat is back, then let
   // the pipeline settle.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid_q || expected_beats.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [15:0] reg_val;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset delays.
      // leave with no session, then tick with no session
      queue_req(cssh_pkg::REQ_EVENT, '0, cssh_pkg::EV_DISCONNECT, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'hFFFF_FFFF, '0, '0, 1'b0, '0);
      // undefined request
      queue_req(2'd3, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1, 16'hFFFF);
      queue_req(cssh_pkg::REQ_START, '0, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'd0, '0, '0, 1'b0, '0);
      // one short of deadline, then send connect
      queue_req(cssh_pkg::REQ_TICK, 32'd999, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'd1000, '0, '0, 1'b0, '0);
      // unexpected in wait
      queue_req(cssh_pkg::REQ_EVENT, 32'd1000, cssh_pkg::EV_JOIN_READY, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_EVENT, 32'd1000, cssh_pkg::EV_CONNECT, '0, 1'b0, '0);
      // acts at once, then join offer
      queue_req(cssh_pkg::REQ_TICK, 32'd1000, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'd2000, '0, '0, 1'b0, 16'hFFFF);
      // zero id
      queue_req(cssh_pkg::REQ_EVENT, 32'd2000, cssh_pkg::EV_FRAGMENT, 16'd0, 1'b1, '0);
      queue_req(cssh_pkg::REQ_EVENT, 32'd2000, cssh_pkg::EV_FRAGMENT, 16'hFFFF, 1'b0, '0);
      queue_req(cssh_pkg::REQ_EVENT, 32'd2000, cssh_pkg::EV_JOIN_READY, '0, 1'b0, '0);
      // add player
      queue_req(cssh_pkg::REQ_TICK, 32'd2000, '0, '0, 1'b0, '0);
      // stale id, then the one that completes
      queue_req(cssh_pkg::REQ_EVENT, 32'd2000, cssh_pkg::EV_FRAGMENT, 16'd5, 1'b1, '0);
      queue_req(cssh_pkg::REQ_EVENT, 32'd2000, cssh_pkg::EV_FRAGMENT, 16'hFFFF, 1'b1, '0);
      // deliver buffer, then silent client
      queue_req(cssh_pkg::REQ_TICK, 32'd2001, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'd7001, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_START, 32'hFFFF_FF00, '0, '0, 1'b0, '0);
      // deadline wraps
      queue_req(cssh_pkg::REQ_TICK, 32'hFFFF_FF00, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_TICK, 32'hFFFF_FFFF, '0, '0, 1'b0, '0);
      // connect wait missed
      queue_req(cssh_pkg::REQ_TICK, 32'd4999, '0, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_EVENT, 32'd4999, cssh_pkg::EV_OTHER, '0, 1'b0, '0);
      queue_req(cssh_pkg::REQ_START, 32'd0, '0, '0, 1'b0, '0);
      // client leaves early
      queue_req(cssh_pkg::REQ_EVENT, 32'd0, cssh_pkg::EV_DISCONNECT, '0, 1'b0, '0);
      wait_drained();

      // Random part: three idling modes, each with its own register setting.
      noise_on = 1'b1;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 13; recv_idle_pct = 48; end
            1: begin send_idle_pct = 48; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int i = 0; i < 5; i++) begin
            case (mode)
               0:       reg_val = 16'hFFFF;
               1:       reg_val = 16'($urandom_range(2000));
               default: reg_val = 16'h0000;
            endcase
            write_reg(cssh_pkg::cssh_reg_type'(i), reg_val);
         end
         stim_ms    = $urandom;
         items_made = 0;
         while (items_made < 700) queue_session();
         wait_drained();
      end

      if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cssh_pkg.sv
hw/rtl/cssh_req_if.sv
hw/rtl/cssh_rsp_if.sv
hw/rtl/cssh_step.sv
hw/rtl/client_session_handshake_fsm_core.sv
tb/sv/tb_client_session_handshake_fsm_core.sv
